[rtl/assert_macros.svh]
// Assertion macros shared by the frame sequencer and result queue of the programmer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

[rtl/slpga_pkg.sv]
// Types, constants and frame builder of the six-lane amplifier programmer.
`default_nettype none
package slpga_pkg;

    localparam int LANES        = 6;
    localparam int FRAME_BITS   = 38;
    localparam int FIFO_DEPTH   = 4;

    localparam logic [5:0]  ALL_PINS      = 6'h3f;
    localparam logic [5:0]  LAST_BIT      = 6'd37;
    localparam logic [5:0]  FRAME_LEN     = 6'd38;
    localparam logic [2:0]  RELEASE_PHASE = 3'd6;
    localparam logic [11:0] FRAME_HEAD    = 12'b100000000001;
    localparam logic [1:0]  FRAME_FUNC    = 2'b01;
    localparam logic [1:0]  FRAME_MARK    = 2'b10;
    localparam logic [11:0] FRAME_TAIL    = 12'b011111111110;

    // Parameter select codes
    localparam logic [1:0] SEL_GAIN2  = 2'd0;
    localparam logic [1:0] SEL_GAIN1  = 2'd1;
    localparam logic [1:0] SEL_OFFSET = 2'd2;
    localparam logic [1:0] SEL_REPEAT = 2'd3;

    // Operation codes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef logic [LANES-1:0][7:0] value_array_t;

    typedef struct packed {
        logic [5:0] pins;
        logic       is_pin_write;
        logic       start_rejected;
        logic       busy_res;
        logic       last;
    } result_t;

    // Results produced by one processed beat
    typedef struct packed {
        logic    push0;
        logic    push1;
        result_t res0;
        result_t res1;
    } push_t;

    // Build the 38-bit frame for one lane, MSB first on the wire
    function automatic logic [FRAME_BITS-1:0] frame_of(input logic [1:0] code,
                                                        input logic [7:0] value);
        frame_of = {FRAME_HEAD, FRAME_FUNC, code, FRAME_MARK, value, FRAME_TAIL};
    endfunction

endpackage
`default_nettype wire

[rtl/slpga_core.sv]
// Frame sequencer: holds the frame state and forms the results of one beat.
`default_nettype none
`include "assert_macros.svh"
module slpga_core (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    advance,
    input  wire logic                    operation,
    input  wire logic [1:0]              parameter_select,
    input  wire slpga_pkg::value_array_t values,
    output slpga_pkg::push_t             push
);
    import slpga_pkg::*;

    value_array_t           values_reg, values_next;
    logic [1:0]             code_reg, code_next;
    logic [5:0]             bit_index_reg, bit_index_next;
    logic [2:0]             phase_reg, phase_next;
    logic                   running_reg, running_next;
    logic [5:0]             pos;
    logic [5:0]             port;
    logic [FRAME_BITS-1:0]  frame;

    // Select the current frame bit on every lane
    assign pos = LAST_BIT - bit_index_reg;

    always_comb
    begin
        port = ALL_PINS;
        frame = '0;
        for (int j = 0; j < LANES; j++)
        begin
            frame = frame_of(code_reg, values_reg[j]);
            port[j] = frame[pos];
        end
    end

    // Next state and results
    always_comb
    begin
        values_next    = values_reg;
        code_next      = code_reg;
        bit_index_next = bit_index_reg;
        phase_next     = phase_reg;
        running_next   = running_reg;
        push           = '0;
        if (advance)
        begin
            if (operation == OP_START)
            begin
                push.push0 = 1'b1;
                if (running_reg)
                begin
                    push.res0 = '{pins: 6'd0, is_pin_write: 1'b0, start_rejected: 1'b1,
                                  busy_res: 1'b0, last: 1'b1};
                end
                else
                begin
                    if (parameter_select != SEL_REPEAT)
                    begin
                        code_next   = parameter_select;
                        values_next = values;
                    end
                    bit_index_next = '0;
                    phase_next     = '0;
                    running_next   = 1'b1;
                    push.res0 = '{pins: 6'd0, is_pin_write: 1'b0, start_rejected: 1'b0,
                                  busy_res: 1'b0, last: 1'b1};
                end
            end
            else if (running_reg)
            begin
                if (bit_index_reg >= FRAME_LEN)
                begin
                    running_next = 1'b0;
                end
                else if (phase_reg == 3'd0)
                begin
                    // Raise all pins, then drop the zero-bit pins
                    push.push0 = 1'b1;
                    push.push1 = 1'b1;
                    push.res0 = '{pins: ALL_PINS, is_pin_write: 1'b1, start_rejected: 1'b0,
                                  busy_res: 1'b0, last: 1'b0};
                    push.res1 = '{pins: port, is_pin_write: 1'b1, start_rejected: 1'b0,
                                  busy_res: 1'b0, last: 1'b1};
                    if (port != 6'd0)
                    begin
                        phase_next = 3'd1;
                    end
                    else
                    begin
                        phase_next     = '0;
                        bit_index_next = bit_index_reg + 6'd1;
                        running_next   = (bit_index_next < FRAME_LEN);
                    end
                end
                else if (phase_reg < RELEASE_PHASE)
                begin
                    phase_next = phase_reg + 3'd1;
                end
                else
                begin
                    // Release: drop all pins and move to the next bit
                    push.push0 = 1'b1;
                    push.res0 = '{pins: 6'd0, is_pin_write: 1'b1, start_rejected: 1'b0,
                                  busy_res: 1'b0, last: 1'b1};
                    phase_next     = '0;
                    bit_index_next = bit_index_reg + 6'd1;
                    running_next   = (bit_index_next < FRAME_LEN);
                end
            end
        end
        push.res0.busy_res = running_next;
        push.res1.busy_res = running_next;
    end

    // Hold frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            values_reg    <= '0;
            code_reg      <= '0;
            bit_index_reg <= '0;
            phase_reg     <= '0;
            running_reg   <= 1'b0;
        end
        else
        begin
            values_reg    <= values_next;
            code_reg      <= code_next;
            bit_index_reg <= bit_index_next;
            phase_reg     <= phase_next;
            running_reg   <= running_next;
        end
    end

    `ASSERT_IMPLY(a_phase_needs_run, clk, rst_n, phase_reg != 3'd0, running_reg,
                  "phase active while idle")
    `ASSERT_IMPLY(a_index_in_frame, clk, rst_n, running_reg, bit_index_reg < FRAME_LEN,
                  "bit index past frame while running")
    `ASSERT_IMPLY(a_pair_order, clk, rst_n, push.push1,
                  push.push0 && push.res1.last && !push.res0.last,
                  "second result without a leading first")

endmodule
`default_nettype wire

[rtl/slpga_fifo.sv]
// Result queue that takes up to two results per cycle and emits one per pop.
`default_nettype none
`include "assert_macros.svh"
module slpga_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire slpga_pkg::push_t   push,
    input  wire logic               pop,
    output logic                    room2,
    output logic                    not_empty,
    output slpga_pkg::result_t      head
);
    import slpga_pkg::*;

    result_t    entry_reg [FIFO_DEPTH];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg, count_next;
    logic [1:0] wr_ptr_next;
    logic       do_pop;

    assign not_empty = (count_reg != 3'd0);
    assign room2     = (count_reg <= 3'(FIFO_DEPTH - 2));
    assign head      = entry_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + {1'b0, push.push0} + {1'b0, push.push1};
        count_next  = count_reg + {2'b0, push.push0} + {2'b0, push.push1} - {2'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
        end
    end

    // Store pushed results
    always_ff @(posedge clk)
    begin
        if (push.push0)
        begin
            entry_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.push1)
        begin
            entry_reg[wr_ptr_reg + 2'd1] <= push.res1;
        end
    end

    `ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_reg <= 3'(FIFO_DEPTH),
                  "queue count above depth")
    `ASSERT_IMPLY(a_push_room, clk, rst_n, push.push0, room2,
                  "push without room for two results")
    `ASSERT_NEXT(a_pop_only, clk, rst_n, do_pop && !push.push0,
                 count_reg == $past(count_reg) - 3'd1, "pop did not lower count")

endmodule
`default_nettype wire

[rtl/six_lane_single_wire_pga_programmer_unit.sv]
// Top level of the six-lane single-wire amplifier programmer.
// Each accepted beat is a timer tick or a frame start. A beat is held in the input
// register, is processed by the frame sequencer, and its zero, one or two results enter a
// four-entry result queue that drives the output channel. A new beat is taken every cycle
// while the queue has room for two results; because the output channel moves one result
// per cycle while out_stall is low, the sustained rate is one beat per cycle for starts,
// idle ticks and mid-phase ticks, while the first tick of each frame bit yields two
// results and so holds back later beats once the queue runs short of room.
`default_nettype none
module six_lane_single_wire_pga_programmer_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       operation,
    input  wire logic [1:0] parameter_select,
    input  wire logic [7:0] value_ch0,
    input  wire logic [7:0] value_ch1,
    input  wire logic [7:0] value_ch2,
    input  wire logic [7:0] value_ch3,
    input  wire logic [7:0] value_ch4,
    input  wire logic [7:0] value_ch5,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [5:0]      pins,
    output logic            is_pin_write,
    output logic            start_rejected,
    output logic            busy_res,
    output logic            last
);
    import slpga_pkg::*;

    logic         in_valid_reg;
    logic         operation_reg;
    logic [1:0]   select_reg;
    value_array_t values_reg;
    logic         advance;
    logic         room2;
    push_t        push;
    result_t      head;

    assign advance  = in_valid_reg && room2;
    assign in_stall = in_valid_reg && !room2;

    // Input register: load a beat whenever the held one moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            operation_reg <= operation;
            select_reg    <= parameter_select;
            values_reg    <= {value_ch5, value_ch4, value_ch3,
                              value_ch2, value_ch1, value_ch0};
        end
    end

    slpga_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (advance),
        .operation        (operation_reg),
        .parameter_select (select_reg),
        .values           (values_reg),
        .push             (push)
    );

    slpga_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (!out_stall),
        .room2     (room2),
        .not_empty (out_valid),
        .head      (head)
    );

    // Drive the result channel from the queue head
    assign pins           = head.pins;
    assign is_pin_write   = head.is_pin_write;
    assign start_rejected = head.start_rejected;
    assign busy_res       = head.busy_res;
    assign last           = head.last;

endmodule
`default_nettype wire
